FILE: hw/rtl/tlms_pkg.sv
// Package: types, schedule tables and index remap for the traffic light mode sequencer
package tlms_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_RUSH      = 2'd1,
        MODE_TURN      = 2'd2,
        MODE_RUSH_TURN = 2'd3
    } mode_t;

    typedef logic [1:0] light_t;

    localparam light_t LIGHT_RED       = 2'd0;
    localparam light_t LIGHT_AMBER     = 2'd1;
    localparam light_t LIGHT_GREEN     = 2'd2;
    localparam light_t LIGHT_BLINK_GRN = 2'd3;

    localparam int TPS_W     = 10;
    localparam int ELAPSED_W = 15;
    localparam int SECS_W    = 5;
    localparam int STEP_W    = 3;

    localparam logic [TPS_W-1:0] TPS_RESET = 10'd1000;

    typedef struct packed {
        mode_t                  mode;
        logic [STEP_W-1:0]      step;
        logic [ELAPSED_W-1:0]   elapsed;
        light_t                 ns;
        light_t                 ew;
    } sched_state_t;

    function automatic logic [3:0] mode_len(input mode_t m);
        logic [3:0] len;
        begin
            unique case (m)
                MODE_NORMAL:    len = 4'd4;
                MODE_RUSH:      len = 4'd6;
                MODE_TURN:      len = 4'd6;
                MODE_RUSH_TURN: len = 4'd8;
                default:        len = 4'd4;
            endcase
            return len;
        end
    endfunction

    function automatic logic [SECS_W-1:0] phase_secs(input mode_t m, input logic [STEP_W-1:0] i);
        logic [SECS_W-1:0] s;
        begin
            s = '0;
            unique case (m)
                MODE_NORMAL: begin
                    case (i)
                        3'd0: s = 5'd10;
                        3'd1: s = 5'd3;
                        3'd2: s = 5'd10;
                        3'd3: s = 5'd3;
                        default: s = 5'd0;
                    endcase
                end
                MODE_RUSH: begin
                    case (i)
                        3'd0: s = 5'd30;
                        3'd1: s = 5'd3;
                        3'd2: s = 5'd1;
                        3'd3: s = 5'd30;
                        3'd4: s = 5'd3;
                        3'd5: s = 5'd1;
                        default: s = 5'd0;
                    endcase
                end
                MODE_TURN: begin
                    case (i)
                        3'd0: s = 5'd10;
                        3'd1: s = 5'd10;
                        3'd2: s = 5'd3;
                        3'd3: s = 5'd10;
                        3'd4: s = 5'd10;
                        3'd5: s = 5'd3;
                        default: s = 5'd0;
                    endcase
                end
                MODE_RUSH_TURN: begin
                    case (i)
                        3'd0: s = 5'd10;
                        3'd1: s = 5'd30;
                        3'd2: s = 5'd3;
                        3'd3: s = 5'd1;
                        3'd4: s = 5'd10;
                        3'd5: s = 5'd30;
                        3'd6: s = 5'd3;
                        default: s = 5'd1;
                    endcase
                end
                default: s = '0;
            endcase
            return s;
        end
    endfunction

    function automatic light_t ns_color(input mode_t m, input logic [STEP_W-1:0] i);
        light_t c;
        begin
            c = LIGHT_RED;
            unique case (m)
                MODE_NORMAL: begin
                    case (i)
                        3'd2: c = LIGHT_GREEN;
                        3'd3: c = LIGHT_AMBER;
                        default: c = LIGHT_RED;
                    endcase
                end
                MODE_RUSH: begin
                    case (i)
                        3'd3: c = LIGHT_GREEN;
                        3'd4: c = LIGHT_AMBER;
                        default: c = LIGHT_RED;
                    endcase
                end
                MODE_TURN: begin
                    case (i)
                        3'd3: c = LIGHT_BLINK_GRN;
                        3'd4: c = LIGHT_GREEN;
                        3'd5: c = LIGHT_AMBER;
                        default: c = LIGHT_RED;
                    endcase
                end
                MODE_RUSH_TURN: begin
                    case (i)
                        3'd4: c = LIGHT_BLINK_GRN;
                        3'd5: c = LIGHT_GREEN;
                        3'd6: c = LIGHT_AMBER;
                        default: c = LIGHT_RED;
                    endcase
                end
                default: c = LIGHT_RED;
            endcase
            return c;
        end
    endfunction

    function automatic light_t ew_color(input mode_t m, input logic [STEP_W-1:0] i);
        light_t c;
        begin
            c = LIGHT_RED;
            if (m == MODE_NORMAL || m == MODE_RUSH) begin
                case (i)
                    3'd0: c = LIGHT_GREEN;
                    3'd1: c = LIGHT_AMBER;
                    default: c = LIGHT_RED;
                endcase
            end else begin
                case (i)
                    3'd0: c = LIGHT_BLINK_GRN;
                    3'd1: c = LIGHT_GREEN;
                    3'd2: c = LIGHT_AMBER;
                    default: c = LIGHT_RED;
                endcase
            end
            return c;
        end
    endfunction

    // 4-bit wraparound; negative results land at 14/15 and wrap to 0 after +1 and length check
    function automatic logic [3:0] remap_index(input mode_t from_m, input mode_t to_m,
                                               input logic [STEP_W-1:0] i);
        logic [3:0] i4;
        logic [3:0] up1;
        logic [3:0] up2;
        logic [3:0] dn1;
        logic [3:0] dn2;
        logic [3:0] r;
        begin
            i4  = {1'b0, i};
            up1 = i4 + 4'd1;
            up2 = i4 + 4'd2;
            dn1 = i4 - 4'd1;
            dn2 = i4 - 4'd2;
            case ({from_m, to_m})
                {MODE_NORMAL, MODE_RUSH}:         r = (i4 >= 4'd2) ? up1 : i4;
                {MODE_NORMAL, MODE_TURN}:         r = (i4 <  4'd2) ? up1 : up2;
                {MODE_NORMAL, MODE_RUSH_TURN}:    r = (i4 <  4'd3) ? up1 : up2;
                {MODE_RUSH, MODE_NORMAL}:         r = (i4 >= 4'd2) ? dn1 : i4;
                {MODE_RUSH, MODE_TURN}:
                    r = (i4 == 4'd3 || i4 == 4'd0) ? up1 : i4;
                {MODE_RUSH, MODE_RUSH_TURN}:      r = (i4 >= 4'd3) ? up1 : i4;
                {MODE_TURN, MODE_NORMAL}:         r = (i4 <  4'd3) ? dn1 : dn2;
                {MODE_TURN, MODE_RUSH}:
                    r = (i4 == 4'd3 || i4 == 4'd0) ? dn1 : i4;
                {MODE_TURN, MODE_RUSH_TURN}:      r = (i4 >= 4'd3) ? up1 : i4;
                {MODE_RUSH_TURN, MODE_NORMAL}:    r = (i4 <  4'd3) ? dn1 : dn2;
                {MODE_RUSH_TURN, MODE_RUSH}:      r = (i4 <  4'd4) ? dn1 : dn2;
                {MODE_RUSH_TURN, MODE_TURN}:      r = (i4 >= 4'd3) ? dn1 : i4;
                default:                          r = i4;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/tlms_step.sv
// Next-state logic for one tick: phase timeout, mode change, index remap and light lookup
module tlms_step
    import tlms_pkg::*;
(
    input  sched_state_t        cur,
    input  logic                rush_hour,
    input  logic                turn_request,
    input  logic [TPS_W-1:0]    ticks_per_second,
    output sched_state_t        nxt,
    output logic                stepped
);

    logic [SECS_W-1:0]      secs;
    logic [ELAPSED_W-1:0]   duration;
    logic [ELAPSED_W:0]     next_cnt;
    mode_t                  new_mode;
    logic [3:0]             idx_remap;
    logic [3:0]             idx_inc;
    logic [STEP_W-1:0]      idx_new;

    assign secs     = phase_secs(cur.mode, cur.step);
    // max 30 * 1023 fits in 15 bits
    assign duration = ELAPSED_W'({{TPS_W{1'b0}}, secs} * {{SECS_W{1'b0}}, ticks_per_second});
    assign next_cnt = {1'b0, cur.elapsed} + {{ELAPSED_W{1'b0}}, 1'b1};
    assign stepped  = (next_cnt >= {1'b0, duration});

    assign new_mode  = mode_t'({turn_request, rush_hour});
    assign idx_remap = remap_index(cur.mode, new_mode, cur.step);
    assign idx_inc   = idx_remap + 4'd1;
    assign idx_new   = (idx_inc >= mode_len(new_mode)) ? '0 : idx_inc[STEP_W-1:0];

    always_comb
    begin
        nxt = cur;
        if (stepped)
        begin
            nxt.mode    = new_mode;
            nxt.step    = idx_new;
            nxt.elapsed = '0;
            nxt.ns      = ns_color(new_mode, idx_new);
            nxt.ew      = ew_color(new_mode, idx_new);
        end
        else
        begin
            nxt.elapsed = next_cnt[ELAPSED_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/traffic_light_mode_sequencer_core.sv
// Traffic light mode sequencer: input register, schedule state, result register
// Latency: two register stages; a tick word is held in the input register, then its result in the result register.
// Throughput: one tick word per cycle while results are taken; the phase timer and remap are combinational.
// in_ready drops only when both the input register and a stalled result register are full.
// Reset (rst_n low, async): normal mode, step 0, timer 0, NS red, EW green,
// ticks_per_second 1000, both registers empty.
module traffic_light_mode_sequencer_core
    import tlms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [TPS_W-1:0]    cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                rush_hour,
    input  logic                turn_request,
    input  logic                show_north_south,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          north_south_light,
    output logic [1:0]          east_west_light,
    output logic [1:0]          shown_light,
    output logic [1:0]          current_mode,
    output logic                stepped
);

    logic [TPS_W-1:0]   tps_reg;

    logic               s1_valid_reg;
    logic               s1_rush_reg;
    logic               s1_turn_reg;
    logic               s1_show_reg;
    logic               s1_advance;

    sched_state_t       state_reg;
    sched_state_t       state_next;
    logic               step_hit;

    logic               out_valid_reg;
    light_t             ns_reg;
    light_t             ew_reg;
    light_t             shown_reg;
    mode_t              mode_reg;
    logic               stepped_reg;

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tps_reg <= TPS_RESET;
        else if (cfg_valid && cfg_ready)
            tps_reg <= cfg_data;
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_rush_reg <= rush_hour;
            s1_turn_reg <= turn_request;
            s1_show_reg <= show_north_south;
        end
    end

    tlms_step u_step (
        .cur              (state_reg),
        .rush_hour        (s1_rush_reg),
        .turn_request     (s1_turn_reg),
        .ticks_per_second (tps_reg),
        .nxt              (state_next),
        .stepped          (step_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode    <= MODE_NORMAL;
            state_reg.step    <= '0;
            state_reg.elapsed <= '0;
            state_reg.ns      <= LIGHT_RED;
            state_reg.ew      <= LIGHT_GREEN;
        end
        else if (s1_advance)
        begin
            state_reg <= state_next;
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            ns_reg      <= state_next.ns;
            ew_reg      <= state_next.ew;
            shown_reg   <= s1_show_reg ? state_next.ns : state_next.ew;
            mode_reg    <= state_next.mode;
            stepped_reg <= step_hit;
        end
    end

    assign out_valid         = out_valid_reg;
    assign north_south_light = ns_reg;
    assign east_west_light   = ew_reg;
    assign shown_light       = shown_reg;
    assign current_mode      = mode_reg;
    assign stepped           = stepped_reg;

`ifndef SYNTHESIS
    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, state_reg.step} < mode_len(state_reg.mode))
        else $error("step index beyond mode length");

    a_timer_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && !step_hit) |=>
            (state_reg.elapsed == $past(state_reg.elapsed) + 15'd1))
        else $error("phase timer did not increment");

    a_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stepped_reg) |-> (state_reg.elapsed == '0))
        else $error("phase change without timer clear");

    a_mode_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (mode_reg == state_reg.mode))
        else $error("reported mode differs from schedule state");
`endif

endmodule

FILE: tb/light_schedule_checker.sv
// Checker: predicts the lamp word for each accepted tick word and compares it with the result
module light_schedule_checker
    import tlms_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [TPS_W-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             rush_hour,
    input  logic             turn_request,
    input  logic             show_north_south,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [1:0]       north_south_light,
    input  logic [1:0]       east_west_light,
    input  logic [1:0]       shown_light,
    input  logic [1:0]       current_mode,
    input  logic             stepped,
    output int               mismatches,
    output int               outstanding,
    output int               words_seen,
    output int               steps_seen
);

    typedef struct packed {
        light_t ns;
        light_t ew;
        light_t shown;
        mode_t  mode;
        logic   stepped;
    } lamp_word_t;

    lamp_word_t       expected_lamps[$];
    lamp_word_t       want;
    logic [TPS_W-1:0] tick_rate;
    mode_t            sched_mode;
    logic [7:0]       sched_step;
    logic [31:0]      sched_elapsed;
    light_t           ns_lamp;
    light_t           ew_lamp;

    function automatic logic [7:0] secs_for_step(input mode_t m, input logic [7:0] i);
        logic [63:0] row;
        begin
            case (m)
                MODE_NORMAL: row = {8'd0, 8'd0, 8'd0, 8'd0, 8'd3, 8'd10, 8'd3, 8'd10};
                MODE_RUSH:   row = {8'd0, 8'd0, 8'd1, 8'd3, 8'd30, 8'd1, 8'd3, 8'd30};
                MODE_TURN:   row = {8'd0, 8'd0, 8'd3, 8'd10, 8'd10, 8'd3, 8'd10, 8'd10};
                default:     row = {8'd1, 8'd3, 8'd30, 8'd10, 8'd1, 8'd3, 8'd30, 8'd10};
            endcase
            return row[i[2:0]*8 +: 8];
        end
    endfunction

    function automatic logic [7:0] steps_in_mode(input mode_t m);
        begin
            case (m)
                MODE_NORMAL: return 8'd4;
                MODE_RUSH:   return 8'd6;
                MODE_TURN:   return 8'd6;
                default:     return 8'd8;
            endcase
        end
    endfunction

    function automatic light_t ns_for_step(input mode_t m, input logic [7:0] i);
        logic [15:0] row;
        begin
            case (m)
                MODE_NORMAL: row = {LIGHT_RED, LIGHT_RED, LIGHT_RED, LIGHT_RED,
                                    LIGHT_AMBER, LIGHT_GREEN, LIGHT_RED, LIGHT_RED};
                MODE_RUSH:   row = {LIGHT_RED, LIGHT_RED, LIGHT_RED, LIGHT_AMBER,
                                    LIGHT_GREEN, LIGHT_RED, LIGHT_RED, LIGHT_RED};
                MODE_TURN:   row = {LIGHT_RED, LIGHT_RED, LIGHT_AMBER, LIGHT_GREEN,
                                    LIGHT_BLINK_GRN, LIGHT_RED, LIGHT_RED, LIGHT_RED};
                default:     row = {LIGHT_RED, LIGHT_AMBER, LIGHT_GREEN, LIGHT_BLINK_GRN,
                                    LIGHT_RED, LIGHT_RED, LIGHT_RED, LIGHT_RED};
            endcase
            return row[i[2:0]*2 +: 2];
        end
    endfunction

    function automatic light_t ew_for_step(input mode_t m, input logic [7:0] i);
        logic [15:0] row;
        begin
            if (m == MODE_NORMAL || m == MODE_RUSH)
                row = {LIGHT_RED, LIGHT_RED, LIGHT_RED, LIGHT_RED,
                       LIGHT_RED, LIGHT_RED, LIGHT_AMBER, LIGHT_GREEN};
            else
                row = {LIGHT_RED, LIGHT_RED, LIGHT_RED, LIGHT_RED,
                       LIGHT_RED, LIGHT_AMBER, LIGHT_GREEN, LIGHT_BLINK_GRN};
            return row[i[2:0]*2 +: 2];
        end
    endfunction

    // 8-bit wrap on the way down
    function automatic logic [7:0] carry_step(input mode_t from_m, input mode_t to_m,
                                              input logic [7:0] i);
        logic [7:0] up1;
        logic [7:0] up2;
        logic [7:0] dn1;
        logic [7:0] dn2;
        begin
            up1 = i + 8'd1;
            up2 = i + 8'd2;
            dn1 = i - 8'd1;
            dn2 = i - 8'd2;
            case ({from_m, to_m})
                {MODE_NORMAL, MODE_RUSH}:      return (i >= 8'd2) ? up1 : i;
                {MODE_NORMAL, MODE_TURN}:      return (i < 8'd2) ? up1 : up2;
                {MODE_NORMAL, MODE_RUSH_TURN}: return (i < 8'd3) ? up1 : up2;
                {MODE_RUSH, MODE_NORMAL}:      return (i >= 8'd2) ? dn1 : i;
                {MODE_RUSH, MODE_TURN}:        return (i == 8'd3 || i == 8'd0) ? up1 : i;
                {MODE_RUSH, MODE_RUSH_TURN}:   return (i >= 8'd3) ? up1 : i;
                {MODE_TURN, MODE_NORMAL}:      return (i < 8'd3) ? dn1 : dn2;
                {MODE_TURN, MODE_RUSH}:        return (i == 8'd3 || i == 8'd0) ? dn1 : i;
                {MODE_TURN, MODE_RUSH_TURN}:   return (i >= 8'd3) ? up1 : i;
                {MODE_RUSH_TURN, MODE_NORMAL}: return (i < 8'd3) ? dn1 : dn2;
                {MODE_RUSH_TURN, MODE_RUSH}:   return (i < 8'd4) ? dn1 : dn2;
                {MODE_RUSH_TURN, MODE_TURN}:   return (i >= 8'd3) ? dn1 : i;
                default:                       return i;
            endcase
        end
    endfunction

    function automatic lamp_word_t advance_schedule(input logic rush, input logic turn,
                                                    input logic show_ns);
        logic [31:0] phase_ticks;
        logic [31:0] next_elapsed;
        logic [7:0]  idx;
        mode_t       m;
        lamp_word_t  w;
        begin
            phase_ticks  = 32'(secs_for_step(sched_mode, sched_step)) * 32'(tick_rate);
            next_elapsed = sched_elapsed + 32'd1;
            w.stepped    = 1'b0;
            if (next_elapsed >= phase_ticks) begin
                m   = mode_t'({turn, rush});
                idx = carry_step(sched_mode, m, sched_step) + 8'd1;
                if (idx >= steps_in_mode(m))
                    idx = 8'd0;
                sched_step    = idx;
                ns_lamp       = ns_for_step(m, idx);
                ew_lamp       = ew_for_step(m, idx);
                sched_mode    = m;
                sched_elapsed = 32'd0;
                w.stepped     = 1'b1;
            end else begin
                sched_elapsed = next_elapsed & 32'h7FFF;
            end
            w.ns    = ns_lamp;
            w.ew    = ew_lamp;
            w.shown = show_ns ? ns_lamp : ew_lamp;
            w.mode  = sched_mode;
            return w;
        end
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        begin
            if (exp_v != act_v) begin
                $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
                mismatches++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_lamps.delete();
            tick_rate     = TPS_RESET;
            sched_mode    = MODE_NORMAL;
            sched_step    = 8'd0;
            sched_elapsed = 32'd0;
            ns_lamp       = LIGHT_RED;
            ew_lamp       = LIGHT_GREEN;
            mismatches    = 0;
            words_seen    = 0;
            steps_seen    = 0;
            outstanding  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tick_rate = cfg_data;
            if (out_valid && out_ready)
            begin
                if (expected_lamps.size() == 0)
                begin
                    $display("%0t: lamp word with none expected, expected nothing, actual %h",
                             $time, {north_south_light, east_west_light, shown_light,
                                     current_mode, stepped});
                    mismatches++;
                end
                else
                begin
                    want = expected_lamps.pop_front();
                    check_field("north_south_light", want.ns, north_south_light);
                    check_field("east_west_light", want.ew, east_west_light);
                    check_field("shown_light", want.shown, shown_light);
                    check_field("current_mode", want.mode, current_mode);
                    check_field("stepped", want.stepped, stepped);
                    words_seen++;
                    if (want.stepped)
                        steps_seen++;
                end
            end
            if (in_valid && in_ready)
                expected_lamps.push_back(advance_schedule(rush_hour, turn_request,
                                                          show_north_south));
            outstanding <= expected_lamps.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top: clock, reset, tick and timer-rate stimulus, pacing and verdict
module tb
    import tlms_pkg::*;
();

    localparam int QUIET_LIMIT = 2000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [TPS_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic             rush_hour = 1'b0;
    logic             turn_request = 1'b0;
    logic             show_north_south = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [1:0]       north_south_light;
    logic [1:0]       east_west_light;
    logic [1:0]       shown_light;
    logic [1:0]       current_mode;
    logic             stepped;

    int mismatches;
    int outstanding;
    int words_seen;
    int steps_seen;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int rate_writes = 0;

    // visits every mode-to-mode switch once
    mode_t mode_tour [0:16] = '{MODE_NORMAL, MODE_NORMAL, MODE_RUSH, MODE_NORMAL, MODE_TURN,
                                MODE_NORMAL, MODE_RUSH_TURN, MODE_RUSH, MODE_RUSH, MODE_TURN,
                                MODE_RUSH, MODE_RUSH_TURN, MODE_TURN, MODE_TURN,
                                MODE_RUSH_TURN, MODE_RUSH_TURN, MODE_NORMAL};

    traffic_light_mode_sequencer_core uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rush_hour         (rush_hour),
        .turn_request      (turn_request),
        .show_north_south  (show_north_south),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .north_south_light (north_south_light),
        .east_west_light   (east_west_light),
        .shown_light       (shown_light),
        .current_mode      (current_mode),
        .stepped           (stepped)
    );

    light_schedule_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rush_hour         (rush_hour),
        .turn_request      (turn_request),
        .show_north_south  (show_north_south),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .north_south_light (north_south_light),
        .east_west_light   (east_west_light),
        .shown_light       (shown_light),
        .current_mode      (current_mode),
        .stepped           (stepped),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .words_seen        (words_seen),
        .steps_seen        (steps_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_tick(input mode_t m, input logic show_ns);
        begin
            in_valid         <= 1'b1;
            rush_hour        <= m[0];
            turn_request     <= m[1];
            show_north_south <= show_ns;
            do @(posedge clk); while (!in_ready);
        end
    endtask

    task automatic idle_gap();
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (outstanding != 0);
        end
    endtask

    task automatic write_rate(input logic [TPS_W-1:0] rate);
        begin
            cfg_valid <= 1'b1;
            cfg_data  <= rate;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            rate_writes++;
        end
    endtask

    // mostly held modes so schedules run deep, with switches and one-tick glitches
    task automatic run_schedule(input logic [TPS_W-1:0] rate, input int send_pct,
                                input int stall, input int count);
        mode_t held;
        mode_t m;
        int    switch_pct;
        begin
            write_rate(rate);
            send_idle_pct = send_pct;
            stall_pct     = stall;
            switch_pct    = (rate == 0) ? 20 : 3;
            held          = mode_t'(2'($urandom_range(3)));
            for (int n = 0; n < count; n++)
            begin
                if ($urandom_range(99) < switch_pct)
                    held = mode_t'(2'($urandom_range(3)));
                m = ($urandom_range(99) < 5) ? mode_t'(2'($urandom_range(3))) : held;
                send_tick(m, 1'($urandom_range(1)));
                idle_gap();
            end
            drain();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset rate: every switch and display combination, no phase ends
        for (int k = 0; k < 8; k++)
            send_tick(mode_t'(k[1:0]), k[2]);
        drain();

        // zero rate: each tick ends a phase
        write_rate('0);
        for (int k = 0; k < 17; k++)
            send_tick(mode_tour[k], k[0]);
        drain();

        run_schedule(10'd1,    0,  0,  80);
        run_schedule(10'd2,    52, 0,  80);
        run_schedule(10'd0,    0,  52, 60);
        run_schedule(10'd3,    16, 16, 70);
        run_schedule(10'd1023, 0,  0,  40);
        run_schedule(10'd1,    0,  52, 80);
        run_schedule(10'd0,    16, 16, 60);
        run_schedule(10'd2,    52, 0,  60);

        repeat (4) @(posedge clk);

        $display("Checked %0d tick words over %0d timer rate settings (0 up to 1023),",
                 words_seen, rate_writes + 1);
        $display("%0d of them ended a phase; pacing ran free, sender-idle, stalled and mixed.",
                 steps_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
